// ===== hdl/relev_pkg.sv =====
// Shared types, constants and step functions for the radar elevation unit.
// No dependencies; every other file but relev_check imports this package.
`default_nettype none

package relev_pkg;

    localparam int RANGE_BITS   = 20;
    localparam int DIV_CELLS    = 30;
    localparam int ROOT_CELLS   = 31;
    localparam int CORDIC_CELLS = 31;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [22:0]        ESQ_Q30     = 23'd7188036;
    localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;

    // a*(1-e2) in meters, rounded to Q8
    localparam logic [63:0] QNUM_W =
        (64'd6378137 * 64'd1066553788 + 64'd2097152) >> 22;
    localparam logic [30:0] QNUM = QNUM_W[30:0];

    // Control bits that ride along with each request through the pipeline
    typedef struct packed {
        logic valid;
        logic neg;
        logic clamp;
        logic degen;
    } side_t;

    typedef struct packed {
        logic [61:0] v;
        logic [61:0] res;
    } root_t;

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_ROT,
        RS_SQUARE,
        RS_TERM,
        RS_ROOT,
        RS_DEN,
        RS_DIV
    } rad_state_t;

    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] a;
        case (idx)
            5'd0:  a = 31'd843314856;
            5'd1:  a = 31'd497837829;
            5'd2:  a = 31'd263043836;
            5'd3:  a = 31'd133525158;
            5'd4:  a = 31'd67021686;
            5'd5:  a = 31'd33543515;
            5'd6:  a = 31'd16775850;
            5'd7:  a = 31'd8388437;
            5'd8:  a = 31'd4194282;
            5'd9:  a = 31'd2097149;
            5'd10: a = 31'd1048575;
            5'd11: a = 31'd524287;
            5'd12: a = 31'd262143;
            5'd13: a = 31'd131071;
            5'd14: a = 31'd65535;
            5'd15: a = 31'd32767;
            5'd16: a = 31'd16383;
            5'd17: a = 31'd8191;
            5'd18: a = 31'd4095;
            5'd19: a = 31'd2047;
            5'd20: a = 31'd1023;
            5'd21: a = 31'd511;
            5'd22: a = 31'd255;
            5'd23: a = 31'd127;
            5'd24: a = 31'd63;
            5'd25: a = 31'd31;
            5'd26: a = 31'd15;
            5'd27: a = 31'd7;
            5'd28: a = 31'd3;
            5'd29: a = 31'd1;
            default: a = 31'd0;
        endcase
        return a;
    endfunction

    // One digit of the bitwise integer square root; bit weight is 1 << sh
    function automatic root_t root_step(input logic [61:0] v, input logic [61:0] res,
                                        input logic [5:0] sh);
        logic [61:0] bitw;
        logic [61:0] sum;
        root_t o;
        bitw = 62'd1 << sh;
        sum  = res + bitw;
        if (v >= sum)
        begin
            o.v   = v - sum;
            o.res = (res >> 1) + bitw;
        end
        else
        begin
            o.v   = v;
            o.res = res >> 1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/radar_elevation_from_range_alt_unit.sv =====
// Radar elevation from slant range and altitude: top level.
// Takes one request per cycle unless the output stalls or a radius pass is busy; the path is
// the 92-cell chain (30 divider, 31 root, 31 CORDIC cells) plus nine stages.
// After reset and after each ref_latitude write, an iterative radius pass runs (sine
// rotation, root, long division) and in_ready stays low until it ends.
// Reset: asynchronous active-low; clears valid bits, FSM state and ref_latitude to zero.
// Depends on relev_pkg, relev_radius, relev_div_cell, relev_root_cell, relev_cordic_cell.
`default_nettype none

module radar_elevation_from_range_alt_unit
    import relev_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [RANGE_BITS-1:0] range_m,
    input  wire logic signed [16:0]    altitude_m,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [30:0]         elevation,
    output logic                       below_altitude,
    output logic                       clamped
);

    // ------------------------------------------------------------------
    // Configuration: ref_latitude at byte address 0, written on the access
    // phase. Any write to it kicks off a fresh radius pass.
    // ------------------------------------------------------------------
    logic [30:0] lat_reg;
    logic        lat_wr;
    logic [30:0] rq;
    logic        busy;

    assign pready = 1'b1;
    assign lat_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {1'b0, lat_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg <= 31'd0;
        end
        else if (lat_wr)
        begin
            lat_reg <= pwdata[30:0];
        end
    end

    relev_radius u_radius (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lat_wr),
        .lat   (lat_reg),
        .rq    (rq),
        .busy  (busy)
    );

    // ------------------------------------------------------------------
    // Flow control: the whole chain advances together unless the output
    // register holds a result that is not taken. Hold everything on stall.
    // ------------------------------------------------------------------
    side_t sd8_reg;
    logic  adv;

    assign adv      = !sd8_reg.valid || out_ready;
    assign in_ready = adv && !busy;

    // ------------------------------------------------------------------
    // Stage 0: capture request, flag degenerate geometry (zero range, or
    // range below altitude).
    // ------------------------------------------------------------------
    side_t                 sd0_reg;
    side_t                 sd0_next;
    logic [RANGE_BITS-1:0] r0_reg;
    logic signed [16:0]    h0_reg;

    always_comb
    begin
        sd0_next       = '0;
        sd0_next.valid = in_valid && in_ready;
        sd0_next.degen = (range_m == 20'd0) ||
                         ($signed({1'b0, range_m}) < $signed({{4{altitude_m[16]}}, altitude_m}));
    end

    // ------------------------------------------------------------------
    // Stage 1: the four products of the law of cosines.
    // ------------------------------------------------------------------
    side_t              sd1_reg;
    logic [39:0]        rr1_reg;
    logic signed [48:0] rqh1_reg;
    logic signed [33:0] hh1_reg;
    logic [50:0]        rqr1_reg;
    logic [39:0]        rr1_next;
    logic signed [48:0] rqh1_next;
    logic signed [33:0] hh1_next;
    logic [50:0]        rqr1_next;

    always_comb
    begin
        rr1_next  = r0_reg * r0_reg;
        rqh1_next = $signed({1'b0, rq}) * h0_reg;
        hh1_next  = h0_reg * h0_reg;
        rqr1_next = rq * r0_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: numerator r^2 - 2Rh - h^2 (Q8) and denominator 2Rr.
    // ------------------------------------------------------------------
    side_t              sd2_reg;
    logic signed [51:0] num2_reg;
    logic [51:0]        den2_reg;
    logic signed [51:0] num2_next;

    assign num2_next = $signed({4'b0000, rr1_reg, 8'd0})
                     - $signed({{2{rqh1_reg[48]}}, rqh1_reg, 1'b0})
                     - $signed({10'd0, hh1_reg, 8'd0});

    // ------------------------------------------------------------------
    // Stage 3: magnitude and sign of the numerator.
    // ------------------------------------------------------------------
    side_t       sd3_reg;
    side_t       sd3_next;
    logic [51:0] mag3_reg;
    logic [51:0] den3_reg;
    logic [51:0] mag3_next;

    always_comb
    begin
        mag3_next    = num2_reg[51] ? 52'(-num2_reg) : num2_reg;
        sd3_next     = sd2_reg;
        sd3_next.neg = num2_reg[51];
    end

    // ------------------------------------------------------------------
    // Stage 4: integer quotient bit and clamp detect (|num| > den).
    // ------------------------------------------------------------------
    side_t       sd4_reg;
    side_t       sd4_next;
    logic [51:0] rem4_reg;
    logic [30:0] q4_reg;
    logic [51:0] den4_reg;
    logic [52:0] diff4;
    logic        ge4;
    logic [51:0] rem4_next;

    always_comb
    begin
        diff4          = {1'b0, mag3_reg} - {1'b0, den3_reg};
        ge4            = !diff4[52];
        rem4_next      = ge4 ? diff4[51:0] : mag3_reg;
        sd4_next       = sd3_reg;
        sd4_next.clamp = ge4 && (diff4[51:0] != 52'd0);
    end

    // ------------------------------------------------------------------
    // Divider chain: one fraction bit per cell.
    // ------------------------------------------------------------------
    side_t       div_side [0:DIV_CELLS];
    logic [51:0] div_rem  [0:DIV_CELLS];
    logic [30:0] div_q    [0:DIV_CELLS];
    logic [51:0] div_d    [0:DIV_CELLS];

    assign div_side[0] = sd4_reg;
    assign div_rem[0]  = rem4_reg;
    assign div_q[0]    = q4_reg;
    assign div_d[0]    = den4_reg;

    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_div
        relev_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .side_in  (div_side[k]),
            .rem_in   (div_rem[k]),
            .q_in     (div_q[k]),
            .d_in     (div_d[k]),
            .side_out (div_side[k+1]),
            .rem_out  (div_rem[k+1]),
            .q_out    (div_q[k+1]),
            .d_out    (div_d[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 5: signed acos argument, clamped to one where flagged.
    // Stage 6: its square. Stage 7: 1 - arg^2 for the root chain.
    // ------------------------------------------------------------------
    side_t              sd5_reg;
    logic signed [31:0] arg5_reg;
    logic signed [31:0] base5;
    logic signed [31:0] arg5_next;
    side_t              sd6_reg;
    logic signed [31:0] arg6_reg;
    logic [60:0]        prod6_reg;
    logic signed [63:0] sq6;
    side_t              sd7_reg;
    logic signed [31:0] arg7_reg;
    logic [61:0]        v7_reg;
    logic [61:0]        v7_next;

    always_comb
    begin
        base5     = div_side[DIV_CELLS].clamp ? 32'sh4000_0000
                                              : $signed({1'b0, div_q[DIV_CELLS]});
        arg5_next = div_side[DIV_CELLS].neg ? -base5 : base5;
        sq6       = arg5_reg * arg5_reg;
        v7_next   = (62'd1 << 60) - {1'b0, prod6_reg};
    end

    // ------------------------------------------------------------------
    // Root chain: sqrt(1 - arg^2), one result bit per cell.
    // ------------------------------------------------------------------
    side_t              rt_side [0:ROOT_CELLS];
    logic [61:0]        rt_v    [0:ROOT_CELLS];
    logic [61:0]        rt_res  [0:ROOT_CELLS];
    logic signed [31:0] rt_arg  [0:ROOT_CELLS];

    assign rt_side[0] = sd7_reg;
    assign rt_v[0]    = v7_reg;
    assign rt_res[0]  = 62'd0;
    assign rt_arg[0]  = arg7_reg;

    for (genvar k = 0; k < ROOT_CELLS; k++)
    begin : g_root
        relev_root_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .sh       (6'(60 - 2 * k)),
            .side_in  (rt_side[k]),
            .v_in     (rt_v[k]),
            .res_in   (rt_res[k]),
            .arg_in   (rt_arg[k]),
            .side_out (rt_side[k+1]),
            .v_out    (rt_v[k+1]),
            .res_out  (rt_res[k+1]),
            .arg_out  (rt_arg[k+1])
        );
    end

    // ------------------------------------------------------------------
    // CORDIC chain: vector (sqrt(1-a^2), a) onto the x axis; z collects asin(a).
    // ------------------------------------------------------------------
    side_t              cd_side [0:CORDIC_CELLS];
    logic signed [33:0] cd_x    [0:CORDIC_CELLS];
    logic signed [33:0] cd_y    [0:CORDIC_CELLS];
    logic signed [33:0] cd_z    [0:CORDIC_CELLS];

    assign cd_side[0] = rt_side[ROOT_CELLS];
    assign cd_x[0]    = $signed({3'b000, rt_res[ROOT_CELLS][30:0]});
    assign cd_y[0]    = $signed({{2{rt_arg[ROOT_CELLS][31]}}, rt_arg[ROOT_CELLS]});
    assign cd_z[0]    = 34'sd0;

    for (genvar k = 0; k < CORDIC_CELLS; k++)
    begin : g_cordic
        relev_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .step     (5'(k)),
            .side_in  (cd_side[k]),
            .x_in     (cd_x[k]),
            .y_in     (cd_y[k]),
            .z_in     (cd_z[k]),
            .side_out (cd_side[k+1]),
            .x_out    (cd_x[k+1]),
            .y_out    (cd_y[k+1]),
            .z_out    (cd_z[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 8 (output register): negate, round half up to Q2.29, saturate,
    // and force zero for degenerate geometry.
    // ------------------------------------------------------------------
    logic signed [30:0] elev8_reg;
    logic               below8_reg;
    logic               clamp8_reg;
    logic signed [34:0] ne8;
    logic signed [34:0] eh8;
    logic signed [30:0] elev8_next;
    side_t              sdf;

    assign sdf = cd_side[CORDIC_CELLS];

    always_comb
    begin
        ne8 = 35'sd1 - $signed({cd_z[CORDIC_CELLS][33], cd_z[CORDIC_CELLS]});
        eh8 = ne8 >>> 1;
        if (sdf.degen)
        begin
            elev8_next = 31'sd0;
        end
        else if (eh8 > 35'sd1073741823)
        begin
            elev8_next = 31'sd1073741823;
        end
        else if (eh8 < -35'sd1073741824)
        begin
            elev8_next = -31'sd1073741824;
        end
        else
        begin
            elev8_next = eh8[30:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage registers. Valid and side-band flag bits reset; payload and output flags do not.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd0_reg <= '0;
            sd1_reg <= '0;
            sd2_reg <= '0;
            sd3_reg <= '0;
            sd4_reg <= '0;
            sd5_reg <= '0;
            sd6_reg <= '0;
            sd7_reg <= '0;
            sd8_reg <= '0;
        end
        else if (adv)
        begin
            sd0_reg <= sd0_next;
            sd1_reg <= sd0_reg;
            sd2_reg <= sd1_reg;
            sd3_reg <= sd3_next;
            sd4_reg <= sd4_next;
            sd5_reg <= div_side[DIV_CELLS];
            sd6_reg <= sd5_reg;
            sd7_reg <= sd6_reg;
            sd8_reg <= sdf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg     <= range_m;
            h0_reg     <= altitude_m;
            rr1_reg    <= rr1_next;
            rqh1_reg   <= rqh1_next;
            hh1_reg    <= hh1_next;
            rqr1_reg   <= rqr1_next;
            num2_reg   <= num2_next;
            den2_reg   <= {rqr1_reg, 1'b0};
            mag3_reg   <= mag3_next;
            den3_reg   <= den2_reg;
            rem4_reg   <= rem4_next;
            q4_reg     <= {30'd0, ge4};
            den4_reg   <= den3_reg;
            arg5_reg   <= arg5_next;
            arg6_reg   <= arg5_reg;
            prod6_reg  <= sq6[60:0];
            arg7_reg   <= arg6_reg;
            v7_reg     <= v7_next;
            elev8_reg  <= elev8_next;
            below8_reg <= sdf.degen;
            clamp8_reg <= sdf.clamp && !sdf.degen;
        end
    end

    assign out_valid      = sd8_reg.valid;
    assign elevation      = elev8_reg;
    assign below_altitude = below8_reg;
    assign clamped        = clamp8_reg;

endmodule

`default_nettype wire

// ===== hdl/relev_div_cell.sv =====
// One restoring-division step cell of the argument divider chain.
// Depends on relev_pkg.
`default_nettype none

module relev_div_cell
    import relev_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire side_t       side_in,
    input  wire logic [51:0] rem_in,
    input  wire logic [30:0] q_in,
    input  wire logic [51:0] d_in,
    output side_t            side_out,
    output logic [51:0]      rem_out,
    output logic [30:0]      q_out,
    output logic [51:0]      d_out
);

    side_t       side_reg;
    logic [51:0] rem_reg;
    logic [30:0] q_reg;
    logic [51:0] d_reg;
    logic [52:0] r2;
    logic [52:0] diff;
    logic        ge;
    logic [51:0] rem_next;

    always_comb
    begin
        r2       = {rem_in, 1'b0};
        diff     = r2 - {1'b0, d_in};
        ge       = (r2 >= {1'b0, d_in});
        rem_next = ge ? diff[51:0] : r2[51:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_in[29:0], ge};
            d_reg   <= d_in;
        end
    end

    assign side_out = side_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign d_out    = d_reg;

endmodule

`default_nettype wire

// ===== hdl/relev_root_cell.sv =====
// One square-root digit cell of the cosine-leg chain.
// Depends on relev_pkg (root_step).
`default_nettype none

module relev_root_cell
    import relev_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [5:0]         sh,
    input  wire side_t              side_in,
    input  wire logic [61:0]        v_in,
    input  wire logic [61:0]        res_in,
    input  wire logic signed [31:0] arg_in,
    output side_t                   side_out,
    output logic [61:0]             v_out,
    output logic [61:0]             res_out,
    output logic signed [31:0]      arg_out
);

    side_t              side_reg;
    root_t              rt_reg;
    root_t              rt_next;
    logic signed [31:0] arg_reg;

    assign rt_next = root_step(v_in, res_in, sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_reg  <= rt_next;
            arg_reg <= arg_in;
        end
    end

    assign side_out = side_reg;
    assign v_out    = rt_reg.v;
    assign res_out  = rt_reg.res;
    assign arg_out  = arg_reg;

endmodule

`default_nettype wire

// ===== hdl/relev_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation cell of the arcsine chain.
// Depends on relev_pkg (atan_q30).
`default_nettype none

module relev_cordic_cell
    import relev_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [4:0]         step,
    input  wire side_t              side_in,
    input  wire logic signed [33:0] x_in,
    input  wire logic signed [33:0] y_in,
    input  wire logic signed [33:0] z_in,
    output side_t                   side_out,
    output logic signed [33:0]      x_out,
    output logic signed [33:0]      y_out,
    output logic signed [33:0]      z_out
);

    side_t              side_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;
    logic signed [33:0] z_next;

    always_comb
    begin
        dx = y_in >>> step;
        dy = x_in >>> step;
        at = $signed({3'b000, atan_q30(step)});
        // drive y toward zero
        if (y_in > 34'sd0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + at;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign side_out = side_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

`default_nettype wire

// ===== hdl/relev_radius.sv =====
// Iterative unit for the earth radius of curvature at the reference latitude.
// Depends on relev_pkg (atan_q30, root_step, rad_state_t).
`default_nettype none

module relev_radius
    import relev_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [30:0] lat,
    output logic [30:0]      rq,
    output logic             busy
);

    rad_state_t         state_reg;
    rad_state_t         state_next;
    logic [5:0]         cnt_reg;
    logic [5:0]         cnt_next;
    logic               pend_reg;
    logic               pend_next;
    logic signed [33:0] x_reg;
    logic signed [33:0] x_next;
    logic signed [33:0] y_reg;
    logic signed [33:0] y_next;
    logic signed [33:0] z_reg;
    logic signed [33:0] z_next;
    logic [30:0]        s2_reg;
    logic [30:0]        s2_next;
    logic [30:0]        t_reg;
    logic [30:0]        t_next;
    root_t              rt_reg;
    root_t              rt_next;
    logic [30:0]        den_reg;
    logic [30:0]        den_next;
    logic [31:0]        rem_reg;
    logic [31:0]        rem_next;
    logic [30:0]        q_reg;
    logic [30:0]        q_next;
    logic [30:0]        rq_reg;
    logic [30:0]        rq_next;

    logic signed [33:0] lat2;
    logic signed [33:0] m1;
    logic signed [33:0] m2;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic signed [31:0] sc;
    logic signed [63:0] sprod;
    logic [53:0]        eprod;
    logic [61:0]        dprod;
    logic               nbit;
    logic [31:0]        r2;
    logic               ge;
    logic               last31;
    logic               last61;

    assign last31 = (cnt_reg == 6'd30);
    assign last61 = (cnt_reg == 6'd60);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RS_IDLE:   if (pend_reg) state_next = RS_ROT;
            RS_ROT:    if (last31) state_next = RS_SQUARE;
            RS_SQUARE: state_next = RS_TERM;
            RS_TERM:   state_next = RS_ROOT;
            RS_ROOT:   if (last31) state_next = RS_DEN;
            RS_DEN:    state_next = RS_DIV;
            RS_DIV:    if (last61) state_next = RS_IDLE;
            default:   state_next = RS_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        lat2  = $signed({{2{lat[30]}}, lat, 1'b0});
        m1    = (lat2 < 34'sd0) ? lat2 + PI_Q30 : lat2;
        m2    = (m1 > HALF_PI_Q30) ? m1 - PI_Q30 : m1;
        dx    = y_reg >>> cnt_reg[4:0];
        dy    = x_reg >>> cnt_reg[4:0];
        at    = $signed({3'b000, atan_q30(cnt_reg[4:0])});
        if (y_reg > 34'sd1073741824)
        begin
            sc = 32'sd1073741824;
        end
        else if (y_reg < -34'sd1073741824)
        begin
            sc = -32'sd1073741824;
        end
        else
        begin
            sc = y_reg[31:0];
        end
        sprod = sc * sc;
        eprod = ESQ_Q30 * s2_reg;
        dprod = t_reg * rt_reg.res[30:0];
        nbit  = (cnt_reg <= 6'd30) ? QNUM[5'(6'd30 - cnt_reg)] : 1'b0;
        r2    = {rem_reg[30:0], nbit};
        ge    = (r2 >= {1'b0, den_reg});

        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        s2_next   = s2_reg;
        t_next    = t_reg;
        rt_next   = rt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        rq_next   = rq_reg;

        case (state_reg)
            RS_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    x_next    = GAIN_Q30;
                    y_next    = 34'sd0;
                    z_next    = m2;
                    cnt_next  = 6'd0;
                end
            end
            RS_ROT:
            begin
                if (z_reg >= 34'sd0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                cnt_next = last31 ? 6'd0 : cnt_reg + 6'd1;
            end
            RS_SQUARE:
            begin
                s2_next = sprod[60:30];
            end
            RS_TERM:
            begin
                t_next     = ONE_Q30 - eprod[53:30];
                rt_next.v  = {1'b0, ONE_Q30 - eprod[53:30], 30'd0};
                rt_next.res = 62'd0;
                cnt_next   = 6'd0;
            end
            RS_ROOT:
            begin
                rt_next  = root_step(rt_reg.v, rt_reg.res, 6'd60 - {cnt_reg[4:0], 1'b0});
                cnt_next = last31 ? 6'd0 : cnt_reg + 6'd1;
            end
            RS_DEN:
            begin
                den_next = dprod[60:30];
                rem_next = 32'd0;
                q_next   = 31'd0;
                cnt_next = 6'd0;
            end
            RS_DIV:
            begin
                rem_next = ge ? r2 - {1'b0, den_reg} : r2;
                q_next   = {q_reg[29:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (last61)
                begin
                    rq_next  = {q_reg[29:0], ge};
                    cnt_next = 6'd0;
                end
            end
            default:
            begin
                cnt_next = 6'd0;
            end
        endcase

        // a new latitude queues a fresh pass once the current one ends
        if (start)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            cnt_reg   <= 6'd0;
            pend_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        s2_reg  <= s2_next;
        t_reg   <= t_next;
        rt_reg  <= rt_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        rq_reg  <= rq_next;
    end

    assign rq   = rq_reg;
    assign busy = pend_reg || (state_reg != RS_IDLE);

endmodule

`default_nettype wire

// ===== hdl/relev_check.sv =====
// Port-level checker for the radar elevation unit, bound to the top level.
// Depends on radar_elevation_from_range_alt_unit port names only.
`default_nettype none

module relev_check (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [30:0] elevation,
    input wire logic               below_altitude,
    input wire logic               clamped
);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(elevation))
        else $error("result changed while stalled");

    // a stalled output blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request accepted during output stall");

    // degenerate geometry gives zero and no clamp
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && below_altitude |-> elevation == 31'sd0 && !clamped)
        else $error("degenerate result not zero");

    // a clamped argument lands near plus or minus a right angle
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> elevation > 31'sd800000000 || elevation < -31'sd800000000)
        else $error("clamped result not near a right angle");

endmodule

bind radar_elevation_from_range_alt_unit relev_check u_relev_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .elevation      (elevation),
    .below_altitude (below_altitude),
    .clamped        (clamped)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for radar_elevation_from_range_alt_unit: bit-exact elevation
// predictor, bursty request driver, stalling result monitor, APB latitude writes.
// Depends on relev_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module testbench;
    import relev_pkg::*;

    localparam logic [2:0] LAT_ADDR    = 3'd0;
    localparam logic [2:0] SPARE_ADDR  = 3'd4;    // no register here; writes must be dropped
    localparam int         DRAIN_WAIT  = 120;     // extra settle time once the queues are empty
    localparam int         CYCLE_LIMIT = 800000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         RANDOM_PER_PHASE = 80;

    localparam longint ONE30 = 64'sd1 << 30;
    localparam longint PI30  = 64'sd3373259426;
    localparam longint HPI30 = 64'sd1686629713;

    localparam longint ARCTAN [0:30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1, 0};

    typedef struct {
        logic [19:0]        rng;
        logic signed [16:0] alt;
    } plot_t;

    typedef struct {
        logic signed [30:0] elev;
        logic               below;
        logic               clamp;
    } angle_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready;
    logic [19:0] range_m;
    logic signed [16:0] altitude_m;
    logic out_valid, out_ready;
    logic signed [30:0] elevation;
    logic below_altitude, clamped;

    radar_elevation_from_range_alt_unit i_dut (.*);

    // Predictor state: latitude register and the earth radius derived from it
    logic [30:0]     lat_reg;
    longint unsigned radius_q8;

    plot_t  plot_queue [$];
    angle_t angle_queue [$];

    int n_sent, n_checked, n_bad, n_clamp, n_below;
    int unsigned cycle;
    bit hold_go;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- arithmetic
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res, bw;
        res = 0;
        bw  = 64'd1 << 62;
        while (bw > v)
            bw >>= 2;
        while (bw != 0)
        begin
            if (v >= res + bw)
            begin
                v   = v - (res + bw);
                res = (res >> 1) + bw;
            end
            else
                res = res >> 1;
            bw >>= 2;
        end
        return res;
    endfunction

    function automatic longint lat_sine(input longint z);
        longint x, y, dx, dy;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 31; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
            else
            begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
        end
        if (y > ONE30) y = ONE30;
        if (y < -ONE30) y = -ONE30;
        return y;
    endfunction

    function automatic longint arcsine(input longint a);
        longint x, y, z, dx, dy;
        x = longint'(floor_root(longint'(ONE30 * ONE30 - a * a)));
        y = a;
        z = 0;
        for (int i = 0; i < 31; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
        end
        return z;
    endfunction

    // Radius of curvature at the latitude, meters in Q8
    function automatic longint unsigned earth_radius(input logic [30:0] lat31);
        longint lat, m, s;
        longint unsigned s2, t, sq, den, qn;
        lat = longint'($signed(lat31)) * 2;
        m = lat % PI30;
        if (m < 0) m += PI30;
        if (m > HPI30) m -= PI30;
        s  = lat_sine(m);
        s2 = longint'(s * s) >> 30;
        t  = ONE30 - ((64'd7188036 * s2) >> 30);
        sq = floor_root(t << 30);
        den = (t * sq) >> 30;
        qn = (64'd6378137 * (ONE30 - 64'd7188036) + (64'd1 << 21)) >> 22;
        return (qn << 30) / den;
    endfunction

    function automatic angle_t elevation_of(input plot_t p);
        angle_t o;
        longint r, h, rq, num, arg, e;
        longint unsigned den, mag, q, rem;
        r = longint'(p.rng);
        h = longint'(p.alt);
        o.below = 1'b0;
        o.clamp = 1'b0;
        if (r == 0 || r < h)
        begin
            o.elev  = '0;
            o.below = 1'b1;
            return o;
        end
        rq  = longint'(radius_q8);
        num = r * r * 256 - 2 * rq * h - h * h * 256;
        den = 2 * rq * r;
        mag = (num < 0) ? -num : num;
        if (mag > den)
        begin
            arg = ONE30;
            o.clamp = 1'b1;
        end
        else
        begin
            // restoring division, Q.30
            q   = (mag >= den) ? 1 : 0;
            rem = mag - q * den;
            for (int i = 0; i < 30; i++)
            begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den)
                begin
                    rem -= den;
                    q |= 1;
                end
            end
            arg = longint'(q);
        end
        if (num < 0)
            arg = -arg;
        e = (-arcsine(arg) + 1) >>> 1;
        if (e > 64'sh3FFFFFFF) e = 64'sh3FFFFFFF;
        if (e < -64'sh40000000) e = -64'sh40000000;
        o.elev = e[30:0];
        return o;
    endfunction

    // ---------------------------------------------------------------- driver
    // Send requests in bursts of random length, separated by random gaps.
    int burst_left, gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        plot_t p;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            range_m    <= '0;
            altitude_m <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                p.rng = range_m;
                p.alt = altitude_m;
                angle_queue.push_back(elevation_of(p));
                n_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (plot_queue.size() > 0)
                begin
                    p = plot_queue.pop_front();
                    range_m    <= p.rng;
                    altitude_m <= p.alt;
                    in_valid   <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(40, 1);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    // Stall at a rate drawn at random from 0, 25, 60 or 90 percent; once, hold off for a long stretch.
    int stall_pct, hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_pct = 0;
            hold_left = 0;
            hold_done = 0;
        end
        else
        begin
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (cycle % 64 == 0)
            begin
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge clk)
    begin
        angle_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (angle_queue.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: result with nothing pending: elev=%0d below=%b clamp=%b",
                             elevation, below_altitude, clamped);
            end
            else
            begin
                want = angle_queue.pop_front();
                n_checked++;
                if (want.clamp) n_clamp++;
                if (want.below) n_below++;
                if (elevation !== want.elev || below_altitude !== want.below ||
                    clamped !== want.clamp)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("ERROR: result %0d: elev exp %0d got %0d, below exp %b got %b, clamp exp %b got %b",
                                 n_checked, want.elev, elevation, want.below, below_altitude,
                                 want.clamp, clamped);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge clk)
    begin
        cycle++;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("timeout: %0d requests sent, %0d results checked", n_sent, n_checked);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == LAT_ADDR)
        begin
            lat_reg   = data[30:0];
            radius_q8 = earth_radius(lat_reg);
        end
    endtask

    task automatic add_plot(input int r, input int h);
        plot_t p;
        p.rng = r[19:0];
        p.alt = h[16:0];
        plot_queue.push_back(p);
    endtask

    // Hold until every request has gone in and every result has come back.
    task automatic drain();
        while (plot_queue.size() > 0 || angle_queue.size() > 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic add_random(input int count);
        int h, r;
        for (int i = 0; i < count; i++)
        begin
            h = $urandom_range(52000) - 2000;
            case ($urandom_range(9))
                0:       r = (h > 1) ? $urandom_range(h - 1) : 0;        // degenerate
                1, 2:    r = (h < 1 ? 1 : h) + $urandom_range(64);       // near vertical
                3:       r = $urandom_range(16, 1);                      // tiny range
                default: r = $urandom_range(1048575);
            endcase
            add_plot(r, h);
        end
    endtask

    logic [31:0] lat_plan [$];

    initial
    begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        hold_go = 0;
        n_sent = 0; n_checked = 0; n_bad = 0; n_clamp = 0; n_below = 0;
        cycle = 0;
        lat_reg   = '0;
        radius_q8 = earth_radius('0);
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed plots at the reset latitude
        add_plot(0, 0);
        add_plot(0, -2000);
        add_plot(0, 50000);
        add_plot(1, 2);
        add_plot(49999, 50000);
        add_plot(50000, 50000);
        add_plot(1048575, 50000);
        add_plot(1048575, -2000);
        add_plot(1048575, 0);
        add_plot(1, 0);
        add_plot(1, -2000);
        add_plot(2, -1);
        add_plot(1000, -2000);
        add_plot(1, 1);
        add_plot(524288, 65535 - 65536);
        add_plot(699050, 43690);
        add_plot(349525, 21845);
        add_plot(100000, 10000);
        drain();

        lat_plan = '{32'd843314856, 32'hCDBC_2558, 32'h7FFF_FFFF, 32'h4000_0000,
                     $urandom(), 32'd0};
        foreach (lat_plan[k])
        begin
            apb_write(LAT_ADDR, lat_plan[k]);
            if (k == 2)
                apb_write(SPARE_ADDR, $urandom());
            add_plot(1048575, -2000);
            add_plot(1, -2000);
            add_random(RANDOM_PER_PHASE);
            if (k == 1)
            begin
                // long receiver hold-off while requests keep coming
                repeat (20) @(posedge clk);
                hold_go = 1;
            end
            drain();
        end

        $display("covered %0d plots over %0d latitude settings: %0d degenerate, %0d clamped",
                 n_checked, lat_plan.size() + 1, n_below, n_clamp);
        if (n_bad == 0 && angle_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches", n_bad);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
